// ===== src/rtp_pkg.sv =====
// Package for the ringtone token parser: field types, character codes and
// duration/note constants. No dependencies.
`timescale 1ns / 1ps

package rtp_pkg;

    // Field widths
    localparam int CHAR_W = 8;
    localparam int DUR_W  = 6;
    localparam int NOTE_W = 8;

    // Default token buffer depth (range 4 to 8)
    localparam int TOKEN_LEN_DEF = 5;

    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [DUR_W-1:0]  dur_t;
    typedef logic [NOTE_W-1:0] note_t;
    typedef logic [3:0]        semi_t;

    // Control characters
    localparam char_t CHAR_SPACE = 8'h20;
    localparam char_t CHAR_END   = 8'h73;  // 's'
    localparam char_t CHAR_SHARP = 8'h23;  // '#'
    localparam char_t CHAR_REST  = 8'h2D;  // '-'

    // Duration digits
    localparam char_t CHAR_D1 = 8'h31;
    localparam char_t CHAR_D2 = 8'h32;
    localparam char_t CHAR_D3 = 8'h33;
    localparam char_t CHAR_D4 = 8'h34;
    localparam char_t CHAR_D6 = 8'h36;
    localparam char_t CHAR_D8 = 8'h38;

    // Note letters, upper case
    localparam char_t CHAR_A = 8'h41;
    localparam char_t CHAR_B = 8'h42;
    localparam char_t CHAR_C = 8'h43;
    localparam char_t CHAR_D = 8'h44;
    localparam char_t CHAR_E = 8'h45;
    localparam char_t CHAR_F = 8'h46;
    localparam char_t CHAR_G = 8'h47;

    // Lower case range and case offset
    localparam char_t CHAR_LC_A  = 8'h61;
    localparam char_t CHAR_LC_Z  = 8'h7A;
    localparam char_t CASE_SHIFT = 8'h20;

    // Durations
    localparam dur_t DUR_NONE = 6'd0;
    localparam dur_t DUR_1    = 6'd1;
    localparam dur_t DUR_2    = 6'd2;
    localparam dur_t DUR_4    = 6'd4;
    localparam dur_t DUR_8    = 6'd8;
    localparam dur_t DUR_16   = 6'd16;
    localparam dur_t DUR_32   = 6'd32;

    // Note codes
    localparam note_t NOTE_NONE = 8'd0;
    localparam note_t NOTE_REST = 8'd100;
    localparam note_t NOTE_BASE = 8'd101;
    localparam note_t NOTE_MAX  = 8'd136;
    localparam note_t OCT_STEP1 = 8'd12;
    localparam note_t OCT_STEP2 = 8'd24;

endpackage

// ===== src/rtp_channels.sv =====
// Valid/ready channel interfaces for the ringtone token parser.
// Depends on rtp_pkg for the payload types.
`timescale 1ns / 1ps

interface rtp_char_if;
    logic           valid;
    logic           ready;
    rtp_pkg::char_t char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

interface rtp_note_if;
    logic           valid;
    logic           ready;
    rtp_pkg::dur_t  duration;
    rtp_pkg::note_t note_code;
    logic           end_of_song;

    modport source (output valid, output duration, output note_code, output end_of_song,
                    input ready);
    modport sink   (input valid, input duration, input note_code, input end_of_song,
                    output ready);
endinterface

// ===== src/rtp_decoder.sv =====
// Combinational token decoder: duration prefix and note letter/sharp/octave.
// Depends on rtp_pkg.
`timescale 1ns / 1ps

module rtp_decoder #(
    parameter int TOKEN_LEN = rtp_pkg::TOKEN_LEN_DEF
) (
    input  rtp_pkg::char_t tok [TOKEN_LEN],
    output rtp_pkg::dur_t  duration,
    output rtp_pkg::note_t note_code
);

    // The decode never looks further than the fifth character
    localparam int WIN = 5;

    rtp_pkg::char_t win [WIN];
    rtp_pkg::char_t n0;
    rtp_pkg::char_t n1;
    rtp_pkg::char_t n2;
    rtp_pkg::char_t upper;
    rtp_pkg::char_t oct;
    rtp_pkg::semi_t semi;
    rtp_pkg::note_t oct_off;
    rtp_pkg::note_t note;
    logic           start_two;
    logic           dur_ok;
    logic           letter_ok;
    logic           sharpable;
    logic           oct_ok;

    // Pad positions beyond the buffer with zero
    generate
        for (genvar g = 0; g < WIN; g++)
        begin : g_win
            if (g < TOKEN_LEN)
            begin : g_used
                assign win[g] = tok[g];
            end
            else
            begin : g_pad
                assign win[g] = '0;
            end
        end
    endgenerate

    // Decode the duration prefix
    always_comb
    begin
        dur_ok    = 1'b1;
        start_two = 1'b0;
        duration  = rtp_pkg::DUR_NONE;
        unique case (win[0])
            rtp_pkg::CHAR_D1:
            begin
                if (win[1] == rtp_pkg::CHAR_D6)
                begin
                    duration  = rtp_pkg::DUR_16;
                    start_two = 1'b1;
                end
                else
                begin
                    duration = rtp_pkg::DUR_1;
                end
            end
            rtp_pkg::CHAR_D3:
            begin
                duration  = rtp_pkg::DUR_32;
                start_two = 1'b1;
            end
            rtp_pkg::CHAR_D2: duration = rtp_pkg::DUR_2;
            rtp_pkg::CHAR_D4: duration = rtp_pkg::DUR_4;
            rtp_pkg::CHAR_D8: duration = rtp_pkg::DUR_8;
            default:          dur_ok   = 1'b0;
        endcase
    end

    // Pick the note characters after the prefix
    assign n0 = start_two ? win[2] : win[1];
    assign n1 = start_two ? win[3] : win[2];
    assign n2 = start_two ? win[4] : win[3];

    // Fold lower case onto upper case
    assign upper = (n0 >= rtp_pkg::CHAR_LC_A && n0 <= rtp_pkg::CHAR_LC_Z)
                 ? n0 - rtp_pkg::CASE_SHIFT : n0;

    // Map the letter to its semitone
    always_comb
    begin
        letter_ok = 1'b1;
        sharpable = 1'b1;
        semi      = 4'd0;
        unique case (upper)
            rtp_pkg::CHAR_C: semi = 4'd0;
            rtp_pkg::CHAR_D: semi = 4'd2;
            rtp_pkg::CHAR_E:
            begin
                semi      = 4'd4;
                sharpable = 1'b0;
            end
            rtp_pkg::CHAR_F: semi = 4'd5;
            rtp_pkg::CHAR_G: semi = 4'd7;
            rtp_pkg::CHAR_A: semi = 4'd9;
            rtp_pkg::CHAR_B:
            begin
                semi      = 4'd11;
                sharpable = 1'b0;
            end
            default:         letter_ok = 1'b0;
        endcase
    end

    // Octave character sits after an optional sharp
    assign oct = (n1 == rtp_pkg::CHAR_SHARP) ? n2 : n1;

    always_comb
    begin
        oct_ok  = 1'b1;
        oct_off = '0;
        unique case (oct)
            rtp_pkg::CHAR_D1: oct_off = '0;
            rtp_pkg::CHAR_D2: oct_off = rtp_pkg::OCT_STEP1;
            rtp_pkg::CHAR_D3: oct_off = rtp_pkg::OCT_STEP2;
            default:          oct_ok  = 1'b0;
        endcase
    end

    // Assemble the note code
    always_comb
    begin
        if (n0 == rtp_pkg::CHAR_REST)
        begin
            note = rtp_pkg::NOTE_REST;
        end
        else if (!letter_ok || !oct_ok)
        begin
            note = rtp_pkg::NOTE_NONE;
        end
        else if (n1 == rtp_pkg::CHAR_SHARP)
        begin
            if (sharpable)
            begin
                note = rtp_pkg::NOTE_BASE + oct_off + {4'd0, semi} + 8'd1;
            end
            else
            begin
                note = rtp_pkg::NOTE_NONE;
            end
        end
        else
        begin
            note = rtp_pkg::NOTE_BASE + oct_off + {4'd0, semi};
        end
    end

    assign note_code = dur_ok ? note : rtp_pkg::NOTE_NONE;

endmodule

// ===== src/ringtone_token_parser.sv =====
// Ringtone token parser top level: token buffer, decoder and result register.
// Depends on rtp_pkg, rtp_channels (rtp_char_if, rtp_note_if) and rtp_decoder.
//
// Usage:
//   char_ch carries one ASCII character per item. Characters are gathered
//   into a buffer of TOKEN_LEN entries; further characters are dropped.
//   A space ends the token and produces one item on note_ch with the
//   duration (1..32, 0 if unknown) and note code (100 rest, 101..136 notes,
//   0 if unknown). An 's' on an empty token produces an end-of-song item.
//   Latency: the result item is valid the cycle after the space or 's' is
//   taken. Throughput: one character per cycle unless note_ch stalls; the
//   decode is a single combinational pass from the token buffer into the
//   result register. While a result is held, char_ch stays ready only if
//   that result is taken in the same cycle; otherwise it waits.
//   Reset clears the token buffer, its length and the result valid flag.
`timescale 1ns / 1ps

module ringtone_token_parser #(
    parameter int TOKEN_LEN = rtp_pkg::TOKEN_LEN_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    rtp_char_if.sink          char_ch,
    rtp_note_if.source        note_ch
);

    localparam int LEN_W = $clog2(TOKEN_LEN + 1);

    rtp_pkg::char_t tok_reg  [TOKEN_LEN];
    logic [LEN_W-1:0] len_reg;
    logic             out_valid_reg;
    rtp_pkg::dur_t    dur_reg;
    rtp_pkg::note_t   note_reg;
    logic             eos_reg;

    rtp_pkg::dur_t    dec_dur;
    rtp_pkg::note_t   dec_note;
    logic             accept;
    logic             is_end;
    logic             is_space;

    // Decode the current token
    rtp_decoder #(
        .TOKEN_LEN (TOKEN_LEN)
    ) u_decoder (
        .tok       (tok_reg),
        .duration  (dec_dur),
        .note_code (dec_note)
    );

    // Accept while the result register is empty or being drained
    assign char_ch.ready = !out_valid_reg || note_ch.ready;
    assign accept        = char_ch.valid && char_ch.ready;
    assign is_end        = (len_reg == '0) && (char_ch.char_in == rtp_pkg::CHAR_END);
    assign is_space      = (char_ch.char_in == rtp_pkg::CHAR_SPACE);

    // Gather characters; clear on space
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            for (int i = 0; i < TOKEN_LEN; i++)
            begin
                tok_reg[i] <= '0;
            end
        end
        else if (accept && !is_end)
        begin
            if (is_space)
            begin
                len_reg <= '0;
                for (int i = 0; i < TOKEN_LEN; i++)
                begin
                    tok_reg[i] <= '0;
                end
            end
            else if (len_reg < LEN_W'(TOKEN_LEN))
            begin
                len_reg <= len_reg + LEN_W'(1);
                for (int i = 0; i < TOKEN_LEN; i++)
                begin
                    if (len_reg == LEN_W'(i))
                    begin
                        tok_reg[i] <= char_ch.char_in;
                    end
                end
            end
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept && (is_end || is_space))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (note_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (accept && is_end)
        begin
            dur_reg  <= rtp_pkg::DUR_NONE;
            note_reg <= rtp_pkg::NOTE_NONE;
            eos_reg  <= 1'b1;
        end
        else if (accept && is_space)
        begin
            dur_reg  <= dec_dur;
            note_reg <= dec_note;
            eos_reg  <= 1'b0;
        end
    end

    assign note_ch.valid       = out_valid_reg;
    assign note_ch.duration    = dur_reg;
    assign note_ch.note_code   = note_reg;
    assign note_ch.end_of_song = eos_reg;

endmodule

// ===== src/rtp_checker.sv =====
// Port-level checks for the ringtone token parser, bound to the top level.
// Depends on rtp_pkg and ringtone_token_parser.
`timescale 1ns / 1ps

module rtp_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input rtp_pkg::char_t char_in,
    input logic           out_valid,
    input logic           out_ready,
    input rtp_pkg::dur_t  duration,
    input rtp_pkg::note_t note_code,
    input logic           end_of_song
);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(duration) && $stable(note_code)
            && $stable(end_of_song))
    else $error("stalled result item changed");

    // A taken space yields a note item next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && char_in == rtp_pkg::CHAR_SPACE |=> out_valid && !end_of_song)
    else $error("space did not produce a note item");

    // End marker carries no note
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_song |-> duration == rtp_pkg::DUR_NONE
            && note_code == rtp_pkg::NOTE_NONE)
    else $error("end marker with non-zero payload");

    // Duration is one of the legal divisors
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> duration == rtp_pkg::DUR_NONE || duration == rtp_pkg::DUR_1
            || duration == rtp_pkg::DUR_2 || duration == rtp_pkg::DUR_4
            || duration == rtp_pkg::DUR_8 || duration == rtp_pkg::DUR_16
            || duration == rtp_pkg::DUR_32)
    else $error("illegal duration");

    // Note code is zero, rest or a note in range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && note_code != rtp_pkg::NOTE_NONE |-> note_code >= rtp_pkg::NOTE_REST
            && note_code <= rtp_pkg::NOTE_MAX)
    else $error("note code out of range");

endmodule

bind ringtone_token_parser rtp_checker u_rtp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (char_ch.valid),
    .in_ready    (char_ch.ready),
    .char_in     (char_ch.char_in),
    .out_valid   (note_ch.valid),
    .out_ready   (note_ch.ready),
    .duration    (note_ch.duration),
    .note_code   (note_ch.note_code),
    .end_of_song (note_ch.end_of_song)
);

// ===== bench/tb_ringtone_token_parser.sv =====
// Testbench for ringtone_token_parser: directed and random character streams,
// checked item by item against a token-decoding predictor held in the bench.
// Depends on rtp_pkg, rtp_channels and the parser top level.
`timescale 1ns / 1ps

module tb_ringtone_token_parser;

    import rtp_pkg::*;

    localparam int TOKEN_LEN    = TOKEN_LEN_DEF;
    localparam int RANDOM_CHARS = 1700;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 3000;
    localparam int TAIL_CYCLES  = 8;
    localparam int SHOWN_FAULTS = 10;

    typedef struct packed {
        dur_t  duration;
        note_t note_code;
        logic  end_of_song;
    } note_item_t;

    logic clk;
    logic rst_n;

    rtp_char_if char_ch ();
    rtp_note_if note_ch ();

    ringtone_token_parser #(
        .TOKEN_LEN (TOKEN_LEN)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .char_ch (char_ch),
        .note_ch (note_ch)
    );

    // Characters waiting to be sent and notes waiting to come back
    char_t      pending_chars[$];
    note_item_t expected_notes[$];

    // Bench copy of the token buffer
    char_t token_buf [TOKEN_LEN];
    int    token_fill;

    int fault_cnt;
    int notes_taken;
    int tx_gap;
    int tx_calm;
    int rx_gap;
    int rx_calm;
    int hold_left;
    int holds_done;
    int quiet_cycles;

    // Clock
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = ~clk;
    end

    // Idle length: mostly none or short, a few long, with calm stretches
    function automatic int draw_idle(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm = calm - 1;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm = $urandom_range(20, 120);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Gathered character at a position, zero past the fill
    function automatic char_t token_char(int pos);
        if (pos >= token_fill || pos >= TOKEN_LEN)
            return '0;
        return token_buf[pos];
    endfunction

    // Pitch from letter, optional sharp and octave digit
    function automatic note_t pitch_code(int start);
        char_t lead;
        char_t nxt;
        char_t up;
        char_t octv;
        int    semi;
        bit    can_sharp;
        lead = token_char(start);
        nxt  = token_char(start + 1);
        if (lead == CHAR_REST)
            return NOTE_REST;
        up = (lead >= CHAR_LC_A && lead <= CHAR_LC_Z) ? char_t'(lead - CASE_SHIFT) : lead;
        can_sharp = 1'b1;
        case (up)
            CHAR_C: semi = 0;
            CHAR_D: semi = 2;
            CHAR_E:
            begin
                semi = 4;
                can_sharp = 1'b0;
            end
            CHAR_F: semi = 5;
            CHAR_G: semi = 7;
            CHAR_A: semi = 9;
            CHAR_B:
            begin
                semi = 11;
                can_sharp = 1'b0;
            end
            default: return NOTE_NONE;
        endcase
        if (nxt == CHAR_SHARP)
        begin
            if (!can_sharp)
                return NOTE_NONE;
            semi = semi + 1;
            octv = token_char(start + 2);
        end
        else
        begin
            octv = nxt;
        end
        if (octv < CHAR_D1 || octv > CHAR_D3)
            return NOTE_NONE;
        return note_t'(int'(NOTE_BASE) + int'(OCT_STEP1) * int'(octv - CHAR_D1) + semi);
    endfunction

    // Duration prefix, then the pitch that follows it
    function automatic note_item_t close_token();
        note_item_t item;
        int         start;
        item  = '0;
        start = 1;
        case (token_char(0))
            CHAR_D1:
            begin
                if (token_char(1) == CHAR_D6)
                begin
                    item.duration = DUR_16;
                    start = 2;
                end
                else
                begin
                    item.duration = DUR_1;
                end
            end
            CHAR_D3:
            begin
                item.duration = DUR_32;
                start = 2;
            end
            CHAR_D2: item.duration = DUR_2;
            CHAR_D4: item.duration = DUR_4;
            CHAR_D8: item.duration = DUR_8;
            default: return item;
        endcase
        item.note_code = pitch_code(start);
        return item;
    endfunction

    // Advance the bench token state by one character
    function automatic void parse_char(input char_t c, output bit produced,
                                       output note_item_t item);
        produced = 1'b0;
        item     = '0;
        if (token_fill == 0 && c == CHAR_END)
        begin
            produced = 1'b1;
            item.end_of_song = 1'b1;
        end
        else if (c == CHAR_SPACE)
        begin
            produced   = 1'b1;
            item       = close_token();
            token_fill = 0;
        end
        else if (token_fill < TOKEN_LEN)
        begin
            token_buf[token_fill] = c;
            token_fill = token_fill + 1;
        end
    endfunction

    function automatic void log_fault(string what, int want, int got);
        if (fault_cnt < SHOWN_FAULTS)
            $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
        fault_cnt = fault_cnt + 1;
    endfunction

    task automatic push_byte(char_t c);
        pending_chars.push_back(c);
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            pending_chars.push_back(char_t'(s[i]));
    endtask

    // Sender: predict on each accepted item, then offer the next one
    always @(posedge clk or negedge rst_n)
    begin : drive_chars
        bit         produced;
        note_item_t item;
        if (!rst_n)
        begin
            char_ch.valid   <= 1'b0;
            char_ch.char_in <= '0;
            tx_gap          <= 0;
            token_fill = 0;
        end
        else
        begin
            if (char_ch.valid && char_ch.ready)
            begin
                parse_char(char_ch.char_in, produced, item);
                if (produced)
                    expected_notes.push_back(item);
            end
            if (!char_ch.valid || char_ch.ready)
            begin
                if (tx_gap > 0)
                begin
                    char_ch.valid <= 1'b0;
                    tx_gap        <= tx_gap - 1;
                end
                else if (pending_chars.size() != 0)
                begin
                    char_ch.valid   <= 1'b1;
                    char_ch.char_in <= pending_chars.pop_front();
                    tx_gap          <= draw_idle(tx_calm);
                end
                else
                begin
                    char_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, plus long hold-offs to back the block up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            note_ch.ready <= 1'b0;
            rx_gap        <= 0;
            hold_left     <= 0;
            holds_done    <= 0;
        end
        else if (hold_left > 0)
        begin
            note_ch.ready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else if (holds_done < 2 && notes_taken >= 100 + 150 * holds_done)
        begin
            note_ch.ready <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            holds_done    <= holds_done + 1;
        end
        else if (rx_gap > 0)
        begin
            note_ch.ready <= 1'b0;
            rx_gap        <= rx_gap - 1;
        end
        else
        begin
            note_ch.ready <= 1'b1;
            rx_gap        <= draw_idle(rx_calm);
        end
    end

    // Monitor: compare each taken note item with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : check_notes
        note_item_t want;
        if (!rst_n)
        begin
            notes_taken <= 0;
        end
        else if (note_ch.valid && note_ch.ready)
        begin
            notes_taken <= notes_taken + 1;
            if (expected_notes.size() == 0)
            begin
                if (fault_cnt < SHOWN_FAULTS)
                    $display("%0t: unexpected note item: dur %0d note %0d end %0b",
                             $realtime, note_ch.duration, note_ch.note_code,
                             note_ch.end_of_song);
                fault_cnt = fault_cnt + 1;
            end
            else
            begin
                want = expected_notes.pop_front();
                if (note_ch.duration !== want.duration)
                    log_fault("duration", want.duration, note_ch.duration);
                if (note_ch.note_code !== want.note_code)
                    log_fault("note_code", want.note_code, note_ch.note_code);
                if (note_ch.end_of_song !== want.end_of_song)
                    log_fault("end_of_song", want.end_of_song, note_ch.end_of_song);
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((char_ch.valid && char_ch.ready) || (note_ch.valid && note_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("ringtone_token_parser verification failed");
                $finish;
            end
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        string dur_words [6];
        string letters;
        string odd_chars;
        int    target;
        int    pick;
        int    n;

        dur_words = '{"1", "2", "4", "8", "16", "32"};
        letters   = "CDEFGABcdefgab";
        odd_chars = "0123456789#-sSabcefgABEG";

        rst_n           = 1'b0;
        char_ch.valid   = 1'b0;
        char_ch.char_in = '0;
        note_ch.ready   = 1'b0;
        fault_cnt       = 0;
        quiet_cycles    = 0;
        tx_calm         = 0;
        rx_calm         = 0;

        // Directed: end marker, space on empty token, sharp at the top octave,
        // top note with the 32 prefix, rest with an overlong tail and byte
        // extremes, plain upper-case note
        push_text("s");
        push_text(" ");
        push_text("16c#3 ");
        push_text("32b3 ");
        push_text("8-");
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h07);
        push_text("z ");
        push_text("4A1 ");

        // Random: mostly well-formed notes, some broken tokens and noise
        target = pending_chars.size() + RANDOM_CHARS;
        while (pending_chars.size() < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                push_byte(CHAR_END);
            end
            else if (pick < 72)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    push_byte(CHAR_D3);
                    push_byte(char_t'($urandom_range(33, 126)));
                end
                else
                begin
                    push_text(dur_words[$urandom_range(0, 5)]);
                end
                if ($urandom_range(0, 6) == 0)
                begin
                    push_byte(CHAR_REST);
                end
                else
                begin
                    push_byte(char_t'(letters[$urandom_range(0, 13)]));
                    if ($urandom_range(0, 3) == 0)
                        push_byte(CHAR_SHARP);
                    push_byte(char_t'(CHAR_D1 + $urandom_range(0, 2)));
                end
                push_byte(CHAR_SPACE);
            end
            else if (pick < 90)
            begin
                if ($urandom_range(0, 1) == 0)
                    push_text(dur_words[$urandom_range(0, 5)]);
                else
                    push_byte(char_t'(CHAR_D1 - 1 + $urandom_range(0, 9)));
                n = $urandom_range(1, 7);
                repeat (n)
                    push_byte(char_t'(odd_chars[$urandom_range(0, odd_chars.len() - 1)]));
                push_byte(CHAR_SPACE);
            end
            else
            begin
                n = $urandom_range(1, 8);
                repeat (n)
                    push_byte(char_t'($urandom_range(0, 255)));
                push_byte(CHAR_SPACE);
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: everything sent and every predicted note taken
        @(negedge clk);
        while (pending_chars.size() != 0 || char_ch.valid || expected_notes.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (fault_cnt == 0)
            $display("ringtone_token_parser verification clean");
        else
            $display("ringtone_token_parser verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
src/rtp_pkg.sv
src/rtp_channels.sv
src/rtp_decoder.sv
src/ringtone_token_parser.sv
src/rtp_checker.sv
bench/tb_ringtone_token_parser.sv
